FILE: hdl/rlt_pkg.sv
// Shared types and constants of the retry lockout tracker.
`default_nettype none

package rlt_pkg;

	// Field widths of one word on each side
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned FLAGS_W  = 4;
	localparam int unsigned SECS_W   = 16;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_SECS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECS  = 2'd2;

	localparam logic [COUNT_W-1:0] FAIL_LIMIT_RST   = 3'd5;
	localparam logic [SECS_W-1:0]  LOCK_SECS_RST    = 16'd180;
	localparam logic [SECS_W-1:0]  WINDOW_SECS_RST  = 16'd300;

	// Request kinds carried in tuser
	localparam logic REQ_ATTEMPT = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	// Result word, lock_flags in the lowest bits
	typedef struct packed {
		logic [FLAGS_W-1:0] released_mask;
		logic               new_lock;
		logic [COUNT_W-1:0] fail_count;
		logic [FLAGS_W-1:0] lock_flags;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

FILE: hdl/retry_lockout_tracker_core.sv
// Failed-attempt lockout tracker: per-channel counters, lock timers and result buffer.
//
// The tracker takes one word per clock while s_tready is high: an attempt report
// (tuser low) for one credential channel, or a one-second tick (tuser high). Each
// word gives exactly one result word. The whole update runs in the cycle the word
// is accepted: per-channel elapsed-time subtracts and limit compares work in parallel,
// so a word can enter every cycle; its result is registered in the output register,
// or in the skid stage while a stalled result holds it. A two-entry output buffer
// (output register plus skid stage) keeps s_tready high while one result waits, so
// a stall on the master side stops input only once both entries are full.
// Configuration writes land at once and are meant for when the block is idle.
`default_nettype none

module retry_lockout_tracker_core
	import rlt_pkg::*;
#(
	parameter int unsigned CHANNELS  = 4,
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave side
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] channel, [2] failed
	input  wire logic                  s_tuser,   // [0] req_type
	// master side
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // [3:0] lock_flags, [6:4] fail_count,
	                                              // [7] new_lock, [11:8] released_mask
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                  take;
	logic                  is_tick;
	logic [CHAN_W-1:0]     req_chan;
	logic                  req_failed;

	logic [COUNT_W-1:0]    fail_limit_q;
	logic [SECS_W-1:0]     lock_secs_q;
	logic [SECS_W-1:0]     window_secs_q;

	logic [TIME_BITS-1:0]  sec_q;
	logic [TIME_BITS-1:0]  sec_d;

	logic [CHANNELS-1:0]   locked_q;
	logic [CHANNELS-1:0]   locked_d;
	logic [COUNT_W-1:0]    count_q [CHANNELS];
	logic [COUNT_W-1:0]    count_d [CHANNELS];
	logic [TIME_BITS-1:0]  stamp_q [CHANNELS];
	logic [TIME_BITS-1:0]  stamp_d [CHANNELS];
	logic [CHANNELS-1:0]   rel_d;
	logic [CHANNELS-1:0]   newlock_d;
	logic [COUNT_W-1:0]    count_sel [CHANNELS];
	logic [CHANNELS-1:0]   count_nz;
	logic [FLAGS_W-1:0]    flags_vec;
	logic [FLAGS_W-1:0]    rel_vec;

	result_t               res_d;
	result_t               out_q;
	result_t               skid_q;
	logic                  out_vld_q;
	logic                  skid_vld_q;
	logic                  drain;

	assign s_tready   = !skid_vld_q;
	assign take       = s_tvalid && s_tready;
	assign is_tick    = take && (s_tuser == REQ_TICK);
	assign req_chan   = s_tdata[CHAN_W-1:0];
	assign req_failed = s_tdata[CHAN_W];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q  <= FAIL_LIMIT_RST;
			lock_secs_q   <= LOCK_SECS_RST;
			window_secs_q <= WINDOW_SECS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAIL_LIMIT:  fail_limit_q  <= cfg_wdata[COUNT_W-1:0];
				REG_LOCK_SECS:   lock_secs_q   <= cfg_wdata[SECS_W-1:0];
				REG_WINDOW_SECS: window_secs_q <= cfg_wdata[SECS_W-1:0];
				default: ;
			endcase
		end
	end

	assign sec_d = is_tick ? sec_q + TIME_BITS'(1) : sec_q;

	// per-channel update
	for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
		logic [TIME_BITS-1:0] elapsed;
		logic                 hit;
		logic [COUNT_W-1:0]   inc;
		logic                 at_limit;

		assign elapsed  = sec_d - stamp_q[g];
		assign hit      = take && (s_tuser == REQ_ATTEMPT) && (32'(req_chan) == g);
		assign inc      = (count_q[g] < fail_limit_q) ? count_q[g] + COUNT_W'(1) : count_q[g];
		assign at_limit = (inc >= fail_limit_q);

		always_comb begin
			locked_d[g]  = locked_q[g];
			count_d[g]   = count_q[g];
			stamp_d[g]   = stamp_q[g];
			rel_d[g]     = 1'b0;
			newlock_d[g] = 1'b0;
			if (is_tick) begin
				if (locked_q[g]) begin
					if (elapsed > TIME_BITS'(lock_secs_q)) begin
						locked_d[g] = 1'b0;
						rel_d[g]    = 1'b1;
					end
				end else if (count_q[g] != '0 && elapsed > TIME_BITS'(window_secs_q)) begin
					count_d[g] = '0;
				end
			end else if (hit) begin
				if (!req_failed) begin
					count_d[g] = '0;
				end else if (!locked_q[g]) begin
					if (at_limit) begin
						// lock: the same stamp now times the lock
						locked_d[g]  = 1'b1;
						count_d[g]   = '0;
						stamp_d[g]   = sec_q;
						newlock_d[g] = 1'b1;
					end else begin
						count_d[g] = inc;
						if (inc == COUNT_W'(1)) begin
							stamp_d[g] = sec_q;
						end
					end
				end
			end
		end

		assign count_sel[g] = hit ? count_d[g] : '0;
		assign count_nz[g]  = (count_q[g] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				locked_q[g] <= 1'b0;
				count_q[g]  <= '0;
				stamp_q[g]  <= '0;
			end else begin
				locked_q[g] <= locked_d[g];
				count_q[g]  <= count_d[g];
				stamp_q[g]  <= stamp_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
		end else begin
			sec_q <= sec_d;
		end
	end

	// assemble the result word
	for (genvar o = 0; o < FLAGS_W; o++) begin : g_flag
		if (o < CHANNELS) begin : g_live
			assign flags_vec[o] = locked_d[o];
			assign rel_vec[o]   = rel_d[o];
		end else begin : g_none
			assign flags_vec[o] = 1'b0;
			assign rel_vec[o]   = 1'b0;
		end
	end

	always_comb begin
		res_d               = '0;
		res_d.lock_flags    = flags_vec;
		res_d.released_mask = rel_vec;
		res_d.new_lock      = |newlock_d;
		for (int c = 0; c < CHANNELS; c++) begin
			res_d.fail_count = res_d.fail_count | count_sel[c];
		end
	end

	// output register with skid stage
	assign drain = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (drain) begin
				skid_vld_q <= 1'b0;
			end
		end else if (take) begin
			if (out_vld_q && !drain) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (drain) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (take) begin
			if (out_vld_q && !drain) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(out_q);

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held without output entry");

	a_locked_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(locked_q & count_nz) == '0)
		else $error("locked channel holds a failure count");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> sec_q == $past(sec_q) + TIME_BITS'(1))
		else $error("seconds counter did not advance on tick");

	a_newlock_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.new_lock) |->
			(out_q.fail_count == '0 && out_q.released_mask == '0))
		else $error("new lock result carries count or release");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the retry lockout tracker core.
`timescale 1ns / 1ps

module tb_top
	import rlt_pkg::*;
;

	typedef struct packed {
		logic       req;
		logic [1:0] chan;
		logic       failed;
	} request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Tracker mirror: configuration and per-channel state
	logic [COUNT_W-1:0] limit_cfg = FAIL_LIMIT_RST;
	logic [SECS_W-1:0]  lock_cfg = LOCK_SECS_RST;
	logic [SECS_W-1:0]  window_cfg = WINDOW_SECS_RST;
	logic [31:0]        now_secs = '0;
	logic [COUNT_W-1:0] miss_cnt [4] = '{default: '0};
	logic [3:0]         lock_bits = '0;
	logic [31:0]        stamp_secs [4] = '{default: '0};

	result_t status_due [$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      hold_cnt = 0;

	retry_lockout_tracker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t advance_tracker(request_t rq);
		result_t            r;
		logic [COUNT_W-1:0] n;
		logic [31:0]        elapsed;
		r = '0;
		if (rq.req == REQ_TICK) begin
			now_secs = now_secs + 32'd1;
			for (int c = 0; c < 4; c++) begin
				elapsed = now_secs - stamp_secs[c];
				if (lock_bits[c]) begin
					if (elapsed > lock_cfg) begin
						lock_bits[c] = 1'b0;
						r.released_mask[c] = 1'b1;
					end
				end else if (miss_cnt[c] != 0 && elapsed > window_cfg) begin
					miss_cnt[c] = '0;
				end
			end
		end else begin
			if (!rq.failed) begin
				miss_cnt[rq.chan] = '0;
			end else if (!lock_bits[rq.chan]) begin
				n = miss_cnt[rq.chan];
				if (n < limit_cfg)
					n = n + 1'b1;
				if (n >= limit_cfg) begin
					// lock restarts the stamp and clears the count
					lock_bits[rq.chan] = 1'b1;
					n = '0;
					stamp_secs[rq.chan] = now_secs;
					r.new_lock = 1'b1;
				end else if (n == 1) begin
					stamp_secs[rq.chan] = now_secs;
				end
				miss_cnt[rq.chan] = n;
			end
			r.fail_count = miss_cnt[rq.chan];
		end
		r.lock_flags = lock_bits;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Predict on every accepted input word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			status_due.push_back(advance_tracker('{s_tuser, s_tdata[1:0], s_tdata[2]}));
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RESULT_W-1:0]);
			if (status_due.size() == 0) begin
				report_mismatch("unexpected word", int'(got), 0);
			end else begin
				want = status_due.pop_front();
				if (got.lock_flags != want.lock_flags)
					report_mismatch("lock_flags", int'(got.lock_flags),
						int'(want.lock_flags));
				if (got.fail_count != want.fail_count)
					report_mismatch("fail_count", int'(got.fail_count),
						int'(want.fail_count));
				if (got.new_lock != want.new_lock)
					report_mismatch("new_lock", int'(got.new_lock), int'(want.new_lock));
				if (got.released_mask != want.released_mask)
					report_mismatch("released_mask", int'(got.released_mask),
						int'(want.released_mask));
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(logic req, logic [1:0] chan, logic failed);
		bit idled;
		idled = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!idled)
				s_tvalid <= 1'b0;
			idled = 1;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= IN_DATA_W'({failed, chan});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_tick();
		send_word(REQ_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FAIL_LIMIT:  limit_cfg = value[COUNT_W-1:0];
			REG_LOCK_SECS:   lock_cfg = value[SECS_W-1:0];
			REG_WINDOW_SECS: window_cfg = value[SECS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(int lim, int lock_s, int win_s);
		wait_drained();
		write_reg(REG_FAIL_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_LOCK_SECS, CFG_DATA_W'(lock_s));
		write_reg(REG_WINDOW_SECS, CFG_DATA_W'(win_s));
	endtask

	task automatic test_directed();
		// reset limits: five failures lock, ignored while locked
		send_word(REQ_ATTEMPT, 2'd0, 1'b0);
		repeat (5) send_word(REQ_ATTEMPT, 2'd0, 1'b1);
		send_word(REQ_ATTEMPT, 2'd0, 1'b1);
		send_word(REQ_ATTEMPT, 2'd0, 1'b0);
		send_word(REQ_TICK, 2'd3, 1'b1);
		// short timers: pending count expires, lock releases
		set_timing(7, 1, 1);
		send_word(REQ_ATTEMPT, 2'd3, 1'b1);
		send_word(REQ_ATTEMPT, 2'd3, 1'b1);
		send_word(REQ_TICK, 2'd0, 1'b0);
		send_word(REQ_TICK, 2'd1, 1'b1);
		// limit of one locks on the first failure
		set_timing(1, 1, 65535);
		send_word(REQ_ATTEMPT, 2'd2, 1'b1);
		send_word(REQ_TICK, 2'd2, 1'b0);
		send_word(REQ_TICK, 2'd2, 1'b0);
		// limit of zero: every failure on an unlocked channel locks
		set_timing(0, 65535, 1);
		send_word(REQ_ATTEMPT, 2'd1, 1'b1);
		send_word(REQ_ATTEMPT, 2'd1, 1'b1);
		send_word(REQ_ATTEMPT, 2'd1, 1'b0);
		send_word(REQ_TICK, 2'd3, 1'b1);
	endtask

	// Failure runs on one channel, ticks mixed in, sometimes closed by a success
	task automatic run_attempts(int count, int tick_pct);
		int         sent;
		logic [1:0] chan;
		int         run_len;
		sent = 0;
		while (sent < count) begin
			chan = 2'($urandom_range(3));
			run_len = $urandom_range(1, 8);
			repeat (run_len) begin
				if ($urandom_range(99) < tick_pct) begin
					send_tick();
					sent++;
				end
				send_word(REQ_ATTEMPT, chan, ($urandom_range(9) != 0));
				sent++;
			end
			if ($urandom_range(2) == 0) begin
				send_word(REQ_ATTEMPT, chan, 1'b0);
				sent++;
			end
		end
	endtask

	task automatic test_random_phase(int count, int lim, int lock_s, int win_s,
			int idle_pct, int recv_pct, int tick_pct);
		set_timing(lim, lock_s, win_s);
		send_idle_pct = idle_pct;
		stall_pct = recv_pct;
		run_attempts(count, tick_pct);
	endtask

	task automatic test_backpressure();
		wait_drained();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cnt = 120;
		run_attempts(40, 30);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(300, 3, 4, 6, 0, 0, 40);
		test_random_phase(300, 7, 10, 3, 76, 0, 40);
		test_random_phase(300, 1, 2, 20, 0, 76, 30);
		test_random_phase(250, 2, 65535, 65535, 11, 11, 20);
		test_random_phase(160, 0, 1, 1, 0, 0, 50);
		test_backpressure();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rlt_pkg.sv
hdl/retry_lockout_tracker_core.sv
bench/tb_top.sv
